// ===== design/arm_dp_pkg.sv =====
`default_nettype none

package arm_dp_pkg;

  localparam logic [3:0] OP_AND = 4'd0;
  localparam logic [3:0] OP_EOR = 4'd1;
  localparam logic [3:0] OP_SUB = 4'd2;
  localparam logic [3:0] OP_RSB = 4'd3;
  localparam logic [3:0] OP_ADD = 4'd4;
  localparam logic [3:0] OP_ORR = 4'd5;
  localparam logic [3:0] OP_MOV = 4'd6;
  localparam logic [3:0] OP_TST = 4'd7;
  localparam logic [3:0] OP_TEQ = 4'd8;
  localparam logic [3:0] OP_CMP = 4'd9;
  localparam logic [3:0] OP_LSL = 4'd10;

  localparam logic [1:0] SHIFT_LSL = 2'd0;
  localparam logic [1:0] SHIFT_LSR = 2'd1;
  localparam logic [1:0] SHIFT_ASR = 2'd2;
  localparam logic [1:0] SHIFT_ROR = 2'd3;

  localparam logic [1:0] ERR_OK    = 2'd0;
  localparam logic [1:0] ERR_IMM   = 2'd1;
  localparam logic [1:0] ERR_OP    = 2'd2;
  localparam logic [1:0] ERR_SHIFT = 2'd3;

  localparam logic [3:0] COND_ALWAYS = 4'hE;
  localparam logic [7:0] MAX_SHIFT   = 8'd31;
  localparam int         NUM_ROT     = 16;

  localparam int IN_BYTES  = 9;
  localparam int OUT_BYTES = 5;

  typedef enum logic [1:0] {
    CLS_COMPUTE,
    CLS_MOVE,
    CLS_TEST
  } op_class_t;

  typedef struct packed {
    logic [3:0]  op;
    logic [3:0]  dest_reg;
    logic [3:0]  first_reg;
    logic        operand_is_imm;
    logic [31:0] imm_value;
    logic [3:0]  second_reg;
    logic        has_shift;
    logic [1:0]  shift_kind;
    logic        shift_by_reg;
    logic [7:0]  shift_amount;
    logic [3:0]  shift_reg;
  } in_item_t;

  typedef struct packed {
    logic                 op_bad;
    op_class_t            cls;
    logic [3:0]           opcode;
    logic [3:0]           rd;
    logic [3:0]           rn;
    logic                 is_imm;
    logic [31:0]          imm;
    logic [NUM_ROT-1:0]   fits;
    logic [3:0]           rm;
    logic                 shifted;
    logic [1:0]           kind;
    logic                 by_reg;
    logic [7:0]           amount;
    logic [3:0]           rs;
  } decode_t;

  typedef struct packed {
    op_class_t   cls;
    logic [3:0]  opcode;
    logic [3:0]  rd;
    logic [3:0]  rn;
    logic [11:0] op2;
    logic        imm_flag;
    logic [1:0]  err;
  } operand_t;

  function automatic logic [3:0] opcode_bits(input logic [3:0] op);
    logic [3:0] bits;
    case (op)
      OP_AND:  bits = 4'h0;
      OP_EOR:  bits = 4'h1;
      OP_SUB:  bits = 4'h2;
      OP_RSB:  bits = 4'h3;
      OP_ADD:  bits = 4'h4;
      OP_ORR:  bits = 4'hC;
      OP_MOV:  bits = 4'hD;
      OP_TST:  bits = 4'h8;
      OP_TEQ:  bits = 4'h9;
      OP_CMP:  bits = 4'hA;
      default: bits = 4'h0;
    endcase
    return bits;
  endfunction

  // Rotate left by twice the rotation index.
  function automatic logic [31:0] rotl_even(input logic [31:0] v, input int r);
    logic [63:0] tmp;
    tmp = {v, v} << (2 * r);
    return tmp[63:32];
  endfunction

endpackage

`default_nettype wire

// ===== design/arm_dp_decode.sv =====
`default_nettype none

module arm_dp_decode (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  output logic                in_ready,
  input  arm_dp_pkg::in_item_t in_item,
  output logic                out_valid,
  input  wire                 out_ready,
  output arm_dp_pkg::decode_t out_item
);

  arm_dp_pkg::decode_t item_next;
  logic                is_lsl;
  logic [3:0]          op_eff;
  logic [31:0]         rot_val;

  always_comb begin
    is_lsl = (in_item.op == arm_dp_pkg::OP_LSL);
    op_eff = is_lsl ? arm_dp_pkg::OP_MOV : in_item.op;
    item_next.op_bad = (in_item.op > arm_dp_pkg::OP_LSL);
    if (op_eff <= arm_dp_pkg::OP_ORR) begin
      item_next.cls = arm_dp_pkg::CLS_COMPUTE;
    end else if (op_eff == arm_dp_pkg::OP_MOV) begin
      item_next.cls = arm_dp_pkg::CLS_MOVE;
    end else begin
      item_next.cls = arm_dp_pkg::CLS_TEST;
    end
    item_next.opcode  = arm_dp_pkg::opcode_bits(op_eff);
    item_next.rd      = in_item.dest_reg;
    item_next.rn      = in_item.first_reg;
    item_next.is_imm  = is_lsl ? 1'b0 : in_item.operand_is_imm;
    item_next.imm     = in_item.imm_value;
    item_next.rm      = is_lsl ? in_item.dest_reg : in_item.second_reg;
    item_next.shifted = is_lsl ? 1'b1 : in_item.has_shift;
    item_next.kind    = is_lsl ? arm_dp_pkg::SHIFT_LSL : in_item.shift_kind;
    item_next.by_reg  = in_item.shift_by_reg;
    item_next.amount  = in_item.shift_amount;
    item_next.rs      = in_item.shift_reg;
    rot_val = '0;
    for (int r = 0; r < arm_dp_pkg::NUM_ROT; r++) begin
      rot_val = arm_dp_pkg::rotl_even(in_item.imm_value, r);
      item_next.fits[r] = (rot_val[31:8] == 24'd0);
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_item <= item_next;
    end
  end

endmodule

`default_nettype wire

// ===== design/arm_dp_operand.sv =====
`default_nettype none

module arm_dp_operand (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  arm_dp_pkg::decode_t  in_item,
  output logic                 out_valid,
  input  wire                  out_ready,
  output arm_dp_pkg::operand_t out_item
);

  arm_dp_pkg::operand_t item_next;
  logic [3:0]           rot;
  logic [7:0]           rot_byte;
  logic [31:0]          rot_val;
  logic [11:0]          reg_field;
  logic                 shift_err;

  always_comb begin
    rot      = 4'd0;
    rot_byte = 8'd0;
    rot_val  = '0;
    // Walk down so the smallest fitting rotation wins.
    for (int r = arm_dp_pkg::NUM_ROT - 1; r >= 0; r--) begin
      if (in_item.fits[r]) begin
        rot_val  = arm_dp_pkg::rotl_even(in_item.imm, r);
        rot      = 4'(r);
        rot_byte = rot_val[7:0];
      end
    end

    reg_field = {8'd0, in_item.rm};
    shift_err = 1'b0;
    if (in_item.shifted) begin
      reg_field[6:5] = in_item.kind;
      if (in_item.by_reg) begin
        reg_field[11:8] = in_item.rs;
        reg_field[4]    = 1'b1;
      end else begin
        reg_field[11:7] = in_item.amount[4:0];
        shift_err       = (in_item.amount > arm_dp_pkg::MAX_SHIFT);
      end
    end

    item_next.cls      = in_item.cls;
    item_next.opcode   = in_item.opcode;
    item_next.rd       = in_item.rd;
    item_next.rn       = in_item.rn;
    item_next.imm_flag = in_item.is_imm;
    item_next.op2      = in_item.is_imm ? {rot, rot_byte} : reg_field;
    if (in_item.op_bad) begin
      item_next.err = arm_dp_pkg::ERR_OP;
    end else if (in_item.is_imm) begin
      item_next.err = (|in_item.fits) ? arm_dp_pkg::ERR_OK : arm_dp_pkg::ERR_IMM;
    end else begin
      item_next.err = shift_err ? arm_dp_pkg::ERR_SHIFT : arm_dp_pkg::ERR_OK;
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_item <= item_next;
    end
  end

endmodule

`default_nettype wire

// ===== design/arm_dp_assemble.sv =====
`default_nettype none

module arm_dp_assemble (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  arm_dp_pkg::operand_t in_item,
  output logic                 out_valid,
  input  wire                  out_ready,
  output logic [31:0]          machine_word,
  output logic [1:0]           error_code
);

  logic [31:0] word_next;
  logic        s_bit;
  logic [3:0]  rn_field;
  logic [3:0]  rd_field;

  always_comb begin
    case (in_item.cls)
      arm_dp_pkg::CLS_COMPUTE: begin
        s_bit    = 1'b0;
        rn_field = in_item.rn;
        rd_field = in_item.rd;
      end
      arm_dp_pkg::CLS_MOVE: begin
        s_bit    = 1'b0;
        rn_field = 4'd0;
        rd_field = in_item.rd;
      end
      arm_dp_pkg::CLS_TEST: begin
        s_bit    = 1'b1;
        rn_field = in_item.rn;
        rd_field = 4'd0;
      end
      default: begin
        s_bit    = 1'b0;
        rn_field = 4'd0;
        rd_field = 4'd0;
      end
    endcase
    if (in_item.err == arm_dp_pkg::ERR_OK) begin
      word_next = {arm_dp_pkg::COND_ALWAYS, 2'b00, in_item.imm_flag, in_item.opcode,
                   s_bit, rn_field, rd_field, in_item.op2};
    end else begin
      word_next = 32'd0;
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      machine_word <= word_next;
      error_code   <= in_item.err;
    end
  end

endmodule

`default_nettype wire

// ===== design/arm_data_processing_encoder.sv =====
// ARM data-processing instruction encoder.
// One decoded instruction enters on the s_ stream and one encoded item leaves
// on the m_ stream for each one accepted, in order. The s_tdata fields are
// op, dest_reg, first_reg, operand_is_imm, imm_value, second_reg, has_shift,
// shift_kind, shift_by_reg, shift_amount and shift_reg, packed from bit 0 up.
// The m_tdata item holds machine_word in bits 31:0 and error_code in 33:32;
// on any error the word is zero.
// The block is a three-stage pipeline: decode with sixteen parallel rotation
// checks, operand2 selection with error priority, and word assembly into the
// output register. An accepted item passes the decode, operand and assemble
// registers in turn before m_tvalid rises, and while m_tready stays high one
// item can be accepted every cycle.
// Each stage holds its item while the stage after it is full, so when the
// receiver holds m_tready low the pipeline fills up to three items and then
// drops s_tready; nothing is lost or repeated.
// A synchronous reset empties all stages; no item is in flight afterwards.
`default_nettype none

module arm_data_processing_encoder (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                s_tvalid,
  output logic                               s_tready,
  // op, dest_reg, first_reg, operand_is_imm, imm_value, second_reg, has_shift,
  // shift_kind, shift_by_reg, shift_amount, shift_reg; zero padded to 72 bits.
  input  wire  [arm_dp_pkg::IN_BYTES*8-1:0]  s_tdata,
  output logic                               m_tvalid,
  input  wire                                m_tready,
  // machine_word, error_code; zero padded to 40 bits.
  output logic [arm_dp_pkg::OUT_BYTES*8-1:0] m_tdata
);

  arm_dp_pkg::in_item_t in_item;
  arm_dp_pkg::decode_t  dec_item;
  arm_dp_pkg::operand_t opd_item;
  logic                 dec_valid;
  logic                 dec_ready;
  logic                 opd_valid;
  logic                 opd_ready;
  logic [31:0]          machine_word;
  logic [1:0]           error_code;

  always_comb begin
    in_item.op             = s_tdata[3:0];
    in_item.dest_reg       = s_tdata[7:4];
    in_item.first_reg      = s_tdata[11:8];
    in_item.operand_is_imm = s_tdata[12];
    in_item.imm_value      = s_tdata[44:13];
    in_item.second_reg     = s_tdata[48:45];
    in_item.has_shift      = s_tdata[49];
    in_item.shift_kind     = s_tdata[51:50];
    in_item.shift_by_reg   = s_tdata[52];
    in_item.shift_amount   = s_tdata[60:53];
    in_item.shift_reg      = s_tdata[64:61];
  end

  arm_dp_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_item   (in_item),
    .out_valid (dec_valid),
    .out_ready (dec_ready),
    .out_item  (dec_item)
  );

  arm_dp_operand u_operand (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (dec_valid),
    .in_ready  (dec_ready),
    .in_item   (dec_item),
    .out_valid (opd_valid),
    .out_ready (opd_ready),
    .out_item  (opd_item)
  );

  arm_dp_assemble u_assemble (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (opd_valid),
    .in_ready     (opd_ready),
    .in_item      (opd_item),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .machine_word (machine_word),
    .error_code   (error_code)
  );

  assign m_tdata = {{(arm_dp_pkg::OUT_BYTES * 8 - 34){1'b0}}, error_code, machine_word};

  a_err_zero_word : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (error_code != arm_dp_pkg::ERR_OK) |-> (machine_word == 32'd0))
    else $error("Errored item carries a nonzero word.");

  a_ok_cond : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (error_code == arm_dp_pkg::ERR_OK)
      |-> (machine_word[31:28] == arm_dp_pkg::COND_ALWAYS))
    else $error("Encoded word lacks the always condition.");

  a_reg_shift_form : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (error_code == arm_dp_pkg::ERR_OK) && !machine_word[25] && machine_word[4]
      |-> !machine_word[7])
    else $error("Register-shifted operand has bit 7 set.");

  a_stage_hold : assert property (@(posedge clk) disable iff (rst)
    opd_valid && !opd_ready |=> opd_valid && $stable(opd_item))
    else $error("Operand stage lost an item while stalled.");

endmodule

`default_nettype wire
